[rtl/exception_handler_range_table_unit_assert.svh]
// Assertion macros for the exception handler range table checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef EXCEPTION_HANDLER_RANGE_TABLE_UNIT_ASSERT_SVH
`define EXCEPTION_HANDLER_RANGE_TABLE_UNIT_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define EHRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("exception handler range table assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define EHRT_ASSERT_NEXT(lbl, ante, cons) \
  `EHRT_ASSERT(lbl, (ante) |=> (cons))

`endif

[rtl/ehrt_pkg.sv]
// Shared types and constants of the exception handler range table unit.
// No dependencies; the comparator, the unit, the checker and the testbench import this package.
package ehrt_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned AddrBits = 32;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [31:0] AddrMask =
      (AddrBits >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << AddrBits) - 64'd1);

  typedef enum logic [1:0] {
    ReqAdd    = 2'd0,
    ReqLookup = 2'd1,
    ReqClear  = 2'd2
  } ehrt_req_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } ehrt_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] code_addr;
    logic [31:0] range_end;
    logic [31:0] catch_target;
    logic [31:0] finally_target;
    logic [7:0]  exc_reg;
  } ehrt_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hit_start;
    logic [31:0] hit_end;
    logic [31:0] hit_catch;
    logic [31:0] hit_finally;
    logic [7:0]  hit_reg;
    logic [4:0]  entry_count;
    logic        status;
  } ehrt_rsp_t;

  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] catch_target;
    logic [31:0] finally_target;
    logic [7:0]  exc_reg;
  } ehrt_entry_t;

  localparam int unsigned EntryW = $bits(ehrt_entry_t);

endpackage

[rtl/ehrt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ehrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ehrt_range_cmp.sv]
// Shared range comparator: tests whether an address lies in [start, end).
// Depends on ehrt_pkg for the entry type and the address mask.
module ehrt_range_cmp import ehrt_pkg::*; (
  input  logic [31:0] addr_i,
  input  ehrt_entry_t entry_i,
  output logic        hit_o
);

  logic [31:0] addr;

  assign addr  = addr_i & AddrMask;
  assign hit_o = (addr >= entry_i.range_start) && (addr < entry_i.range_end);

endmodule

[rtl/exception_handler_range_table_unit.sv]
// An add or clear passes from the idle state through the finish state to the output
// register; a lookup first compares its entries (newest first, one per cycle) in the scan state.
// No new request is taken until the last result is in the output register, since the
// single comparator walks the entry RAM one entry a cycle.
// Reset clears the entry count and the handshake state; the entry RAM is not cleared.
module exception_handler_range_table_unit import ehrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ehrt_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ehrt_rsp_t out_data_o
);

  ehrt_state_e state_q, state_d;
  ehrt_req_t   req_q, req_d;
  ehrt_rsp_t   res_q, res_d;
  ehrt_rsp_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic        last_q, last_d;

  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [IdxW-1:0] top_idx;
  ehrt_entry_t     ram_wdata;
  ehrt_entry_t     ram_rdata;
  logic [EntryW-1:0] ram_rdata_raw;
  logic            hit;

  assign top_idx = IdxW'(count_q - CntW'(1));

  assign ram_wdata.range_start    = in_data_i.code_addr & AddrMask;
  assign ram_wdata.range_end      = in_data_i.range_end & AddrMask;
  assign ram_wdata.catch_target   = in_data_i.catch_target & AddrMask;
  assign ram_wdata.finally_target = in_data_i.finally_target & AddrMask;
  assign ram_wdata.exc_reg        = in_data_i.exc_reg;
  assign ram_rdata = ehrt_entry_t'(ram_rdata_raw);

  ehrt_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  ehrt_range_cmp u_cmp (
    .addr_i (req_q.code_addr),
    .entry_i(ram_rdata),
    .hit_o  (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          res_d   = '0;
          state_d = StFinish;
          case (in_data_i.req_type)
            ReqAdd: begin
              if (count_q < CntW'(TableEntries)) begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                res_d.status = 1'b1;
              end
            end
            ReqLookup: begin
              if (count_q != '0) begin
                ram_re    = 1'b1;
                ram_raddr = top_idx;
                idx_d     = top_idx - IdxW'(1);
                last_d    = (top_idx == '0);
                state_d   = StScan;
              end
            end
            ReqClear: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        if (hit) begin
          res_d.found       = 1'b1;
          res_d.hit_start   = ram_rdata.range_start;
          res_d.hit_end     = ram_rdata.range_end;
          res_d.hit_catch   = ram_rdata.catch_target;
          res_d.hit_finally = ram_rdata.finally_target;
          res_d.hit_reg     = ram_rdata.exc_reg;
          state_d           = StFinish;
        end else if (last_q) begin
          state_d = StFinish;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_q - IdxW'(1);
          last_d = (idx_q == '0);
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = res_q;
          out_d.entry_count = 5'(count_q);
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/ehrt_checker.sv]
// Port-level checker for the exception handler range table unit, bound to the top.
// Depends on ehrt_pkg and on the assertion macro header.
`include "exception_handler_range_table_unit_assert.svh"

module ehrt_checker import ehrt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input ehrt_req_t in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ehrt_rsp_t out_data_o
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  `EHRT_ASSERT_NEXT(busy_after_in_xfer, in_xfer, !in_ready_o)
  `EHRT_ASSERT_NEXT(out_held_while_stalled, out_stall, out_valid_o && $stable(out_data_o))
  `EHRT_ASSERT(full_drop_not_found, !(out_valid_o && out_data_o.status && out_data_o.found))
  `EHRT_ASSERT(count_in_range, !out_valid_o || (out_data_o.entry_count <= 5'(TableEntries)))

endmodule

bind exception_handler_range_table_unit ehrt_checker u_ehrt_checker (.*);

[verif/exception_handler_range_table_unit_tb.sv]
// Self-checking testbench for exception_handler_range_table_unit: add, lookup, clear and
// undefined requests are checked against a shadow copy of the handler table.
// Depends on ehrt_pkg and the unit itself, which in turn needs the RAM and the range comparator.
module exception_handler_range_table_unit_tb;
  import ehrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ReqUndefined = 2'd3;
  localparam int unsigned RunLimit = 1_000_000;
  localparam int unsigned StallCycles = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  ehrt_req_t in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  ehrt_rsp_t out_data_o;

  ehrt_entry_t shadow_tbl [TableEntries];
  int unsigned shadow_count = 0;
  ehrt_rsp_t   expected_rsps [$];
  ehrt_rsp_t   next_rsp;
  int          err_cnt = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_reqs = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;

  exception_handler_range_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Innermost handler: the newest entry whose range covers the address wins.
  function automatic ehrt_rsp_t apply_table_request(input ehrt_req_t r);
    ehrt_rsp_t   rsp;
    logic [31:0] addr;
    int          i;
    rsp = '0;
    addr = r.code_addr & AddrMask;
    case (r.req_type)
      ReqAdd: begin
        if (shadow_count < TableEntries) begin
          shadow_tbl[shadow_count].range_start    = addr;
          shadow_tbl[shadow_count].range_end      = r.range_end & AddrMask;
          shadow_tbl[shadow_count].catch_target   = r.catch_target & AddrMask;
          shadow_tbl[shadow_count].finally_target = r.finally_target & AddrMask;
          shadow_tbl[shadow_count].exc_reg        = r.exc_reg;
          shadow_count++;
        end else begin
          rsp.status = 1'b1;
        end
      end
      ReqLookup: begin
        for (i = int'(shadow_count) - 1; i >= 0 && !rsp.found; i--) begin
          if (addr >= shadow_tbl[i].range_start && addr < shadow_tbl[i].range_end) begin
            rsp.found       = 1'b1;
            rsp.hit_start   = shadow_tbl[i].range_start;
            rsp.hit_end     = shadow_tbl[i].range_end;
            rsp.hit_catch   = shadow_tbl[i].catch_target;
            rsp.hit_finally = shadow_tbl[i].finally_target;
            rsp.hit_reg     = shadow_tbl[i].exc_reg;
          end
        end
      end
      ReqClear: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    rsp.entry_count = shadow_count[4:0];
    return rsp;
  endfunction

  function automatic ehrt_req_t make_req(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic [31:0] last, input logic [31:0] catch_off,
                                         input logic [31:0] fin_off, input logic [7:0] reg_id);
    ehrt_req_t r;
    r.req_type       = kind;
    r.code_addr      = addr;
    r.range_end      = last;
    r.catch_target   = catch_off;
    r.finally_target = fin_off;
    r.exc_reg        = reg_id;
    return r;
  endfunction

  function automatic logic [31:0] pick_probe_addr();
    ehrt_entry_t ent;
    if (shadow_count == 0 || $urandom_range(3) == 0) begin
      return $urandom_range(1) ? $urandom : 32'h1000 + $urandom_range(400);
    end
    ent = shadow_tbl[$urandom_range(shadow_count - 1)];
    case ($urandom_range(4))
      0: return ent.range_start;
      1: return ent.range_end - 32'd1;
      2: return ent.range_end;
      3: return ent.range_start - 32'd1;
      default: return ent.range_start + $urandom_range(ent.range_end - ent.range_start);
    endcase
  endfunction

  task automatic send_req(input ehrt_req_t r);
    ehrt_rsp_t exp_rsp;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    exp_rsp = apply_table_request(r);
    expected_rsps = {expected_rsps, exp_rsp};
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int i;
    send_req(make_req(ReqLookup, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00));
    send_req(make_req(ReqUndefined, '1, '1, '1, '1, 8'hFF));
    send_req(make_req(ReqAdd, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'hFF));
    send_req(make_req(ReqAdd, 32'h10, 32'h20, 32'h0, 32'hFFFF_FFFF, 8'h00));
    send_req(make_req(ReqAdd, 32'h30, 32'h30, 32'h1234, 32'h5678, 8'h5A));
    send_req(make_req(ReqAdd, 32'h50, 32'h40, 32'h2345, 32'h6789, 8'hA5));
    send_req(make_req(ReqLookup, 32'h15, '0, '0, '0, 8'h00));
    send_req(make_req(ReqLookup, 32'h30, '0, '0, '0, 8'h00));
    send_req(make_req(ReqLookup, 32'hFFFF_FFFF, '0, '0, '0, 8'h00));
    send_req(make_req(ReqLookup, 32'hFFFF_FFFE, '0, '0, '0, 8'h00));
    for (i = 4; i < TableEntries; i++) begin
      send_req(make_req(ReqAdd, 32'h100 * i, 32'h100 * i + 32'h80, 32'h7000 + i,
                        32'h9000 + i, 8'(i)));
    end
    send_req(make_req(ReqAdd, 32'h0, 32'h10, 32'h1, 32'h2, 8'h33));
    send_req(make_req(ReqLookup, 32'h440, '0, '0, '0, 8'h00));
    send_req(make_req(ReqClear, '1, '1, '1, '1, 8'hFF));
    send_req(make_req(ReqLookup, 32'h15, '0, '0, '0, 8'h00));
    wait_drained();
  endtask

  // Mostly lookups aimed at range edges plus adds of nested, narrow and inverted ranges.
  task automatic test_random_traffic(input int n_items);
    ehrt_req_t   r;
    ehrt_entry_t ent;
    int          pick;
    for (int n = 0; n < n_items; n++) begin
      r = make_req(ReqAdd, $urandom, $urandom, $urandom, $urandom, 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 38) begin
        case ($urandom_range(3))
          1: begin
            if (shadow_count > 0) begin
              ent = shadow_tbl[$urandom_range(shadow_count - 1)];
              if (ent.range_end > ent.range_start) begin
                r.code_addr = ent.range_start +
                              $urandom_range(ent.range_end - ent.range_start - 32'd1);
                r.range_end = r.code_addr + 32'd1 +
                              $urandom_range(ent.range_end - r.code_addr - 32'd1);
              end
            end
          end
          2: begin
            r.code_addr = 32'h1000 + $urandom_range(255);
            r.range_end = r.code_addr + $urandom_range(64);
          end
          3: begin
            r.range_end = r.code_addr - $urandom_range(3);
          end
          default: begin
          end
        endcase
      end else if (pick < 95) begin
        r.req_type  = ReqLookup;
        r.code_addr = pick_probe_addr();
      end else if (pick < 97) begin
        r.req_type = ReqClear;
      end else begin
        r.req_type = ReqUndefined;
      end
      send_req(r);
    end
  endtask

  task automatic test_output_backpressure();
    stall_reqs++;
    test_random_traffic(24);
    wait_drained();
    test_random_traffic(16);
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      stall_left = StallCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("Result transfer arrived with no request outstanding.");
        err_cnt++;
      end else begin
        next_rsp = expected_rsps.pop_front();
        check_field("found", 32'(next_rsp.found), 32'(out_data_o.found));
        check_field("hit_start", next_rsp.hit_start, out_data_o.hit_start);
        check_field("hit_end", next_rsp.hit_end, out_data_o.hit_end);
        check_field("hit_catch", next_rsp.hit_catch, out_data_o.hit_catch);
        check_field("hit_finally", next_rsp.hit_finally, out_data_o.hit_finally);
        check_field("hit_reg", 32'(next_rsp.hit_reg), 32'(out_data_o.hit_reg));
        check_field("entry_count", 32'(next_rsp.entry_count), 32'(out_data_o.entry_count));
        check_field("status", 32'(next_rsp.status), 32'(out_data_o.status));
      end
    end
  end

  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    tx_idle_pct = 24;
    rx_idle_pct = 69;
    test_random_traffic(620);
    test_output_backpressure();
    wait_drained();
    tx_idle_pct = 69;
    rx_idle_pct = 24;
    test_random_traffic(620);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(620);
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
